>>> rtl/lzw_variable_width_decoder_macros.svh
// assertion helpers used by the expand module
`ifndef LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH
`define LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH

// same-cycle implication
`define LZWVD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZWVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lzwvd_pkg.sv
`default_nettype none
package lzwvd_pkg;

  localparam int unsigned TABLE_ENTRIES       = 4096;
  localparam int unsigned CODE_W              = 12;
  localparam int unsigned FREE_W              = 13;
  localparam int unsigned LEN_W               = 12;
  localparam int unsigned OLEN_W              = 27;
  localparam int unsigned CNT_W               = 7;
  localparam int unsigned CHUNK_MAX           = 64;
  localparam int unsigned CHUNK_BYTES_DEFAULT = 64;
  localparam int unsigned CMD_FIFO_DEPTH      = 2;

  localparam logic [3:0]        CW_MIN      = 4'd9;
  localparam logic [3:0]        CW_MAX      = 4'd12;
  localparam logic [CODE_W-1:0] CLR_CODE    = 12'd256;
  localparam logic [CODE_W-1:0] END_CODE    = 12'd257;
  localparam logic [CODE_W-1:0] LIT_LIMIT   = 12'd256;
  localparam logic [FREE_W-1:0] FIRST_FREE  = 13'd258;
  localparam logic [FREE_W-1:0] FREE_LIMIT  = 13'd4096;
  localparam logic [OLEN_W-1:0] OLEN_RESET  = 27'd65536;

  typedef enum logic [2:0] {
    K_NONE,
    K_CLEAR,
    K_EOI,
    K_LITERAL,
    K_STRING,
    K_INVALID
  } cmd_kind_t;

  typedef enum logic [1:0] {
    STAT_RUN,
    STAT_COMPLETE,
    STAT_SHORT,
    STAT_INVALID
  } status_t;

  typedef enum logic [1:0] {
    PV_NONE,
    PV_CLEARED,
    PV_CODE
  } prev_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_WALK,
    S_DRAIN,
    S_SEND
  } exp_state_t;

  typedef struct packed {
    logic              new_strip;
    cmd_kind_t         kind;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prev;
    logic [CODE_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        first;
    logic [7:0]        last;
    logic [LEN_W-1:0]  len;
  } tab_entry_t;

endpackage
`default_nettype wire

>>> rtl/lzwvd_if.sv
`default_nettype none
interface lzwvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_strip;

  modport source (output valid, output in_byte, output new_strip, input ready);
  modport sink (input valid, input in_byte, input new_strip, output ready);
endinterface

interface lzwvd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word0;
  logic [63:0] data_word1;
  logic [63:0] data_word2;
  logic [63:0] data_word3;
  logic [63:0] data_word4;
  logic [63:0] data_word5;
  logic [63:0] data_word6;
  logic [63:0] data_word7;
  logic [6:0]  byte_count;
  logic        last_chunk;
  logic [1:0]  status;

  modport source (output valid, output data_word0, output data_word1, output data_word2,
                  output data_word3, output data_word4, output data_word5,
                  output data_word6, output data_word7, output byte_count,
                  output last_chunk, output status, input ready);
  modport sink (input valid, input data_word0, input data_word1, input data_word2,
                input data_word3, input data_word4, input data_word5,
                input data_word6, input data_word7, input byte_count,
                input last_chunk, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/lzw_variable_width_decoder.sv
`default_nettype none
// TIFF LZW strip decoder with 9 to 12 bit codes and early width change. Compressed
// bytes enter on code_stream, decoded bytes leave on byte_stream in chunks of up
// to BYTES_PER_CHUNK, the last chunk of a word carrying the strip status. The
// front unpacks one byte per cycle into a two-entry command queue while it has
// room; the back takes one command at a time: a byte that completes no string is
// retired without leaving idle, a string at the pace of the chain walk over the
// table read port and the in-order read of the string stack. Tables need no
// clearing pass after reset; output_length resets to 65536 and is written through
// cfg_wr_en and cfg_wr_data; users must do so only while the block is idle, unenforced.
module lzw_variable_width_decoder import lzwvd_pkg::*; #(
  parameter int unsigned BYTES_PER_CHUNK = CHUNK_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  lzwvd_in_if.sink          code_stream,
  lzwvd_out_if.source       byte_stream,
  input  logic              cfg_wr_en,
  input  logic [OLEN_W-1:0] cfg_wr_data
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  lzwvd_unpack u_unpack (
    .clk         (clk),
    .rst         (rst),
    .code_stream (code_stream),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd),
    .cmd_ready   (front_ready)
  );

  lzwvd_cmd_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_data  (front_cmd),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_data   (back_cmd),
    .pop_ready  (back_ready)
  );

  lzwvd_expand #(
    .BYTES_PER_CHUNK (BYTES_PER_CHUNK)
  ) u_expand (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (back_valid),
    .cmd         (back_cmd),
    .cmd_ready   (back_ready),
    .byte_stream (byte_stream),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule
`default_nettype wire

>>> rtl/lzwvd_cmd_fifo.sv
`default_nettype none
module lzwvd_cmd_fifo import lzwvd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_data,
  input  logic pop_ready
);

  localparam int unsigned AW = $clog2(CMD_FIFO_DEPTH);

  cmd_t          slots [CMD_FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = (count != (AW+1)'(CMD_FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lzwvd_unpack.sv
`default_nettype none
module lzwvd_unpack import lzwvd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lzwvd_in_if.sink   code_stream,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  logic [23:0]       bitbuf, bitbuf_next;
  logic [4:0]        held, held_next;
  logic [3:0]        width, width_next;
  logic [FREE_W-1:0] free_idx, free_idx_next;
  prev_mode_t        mode, mode_next;
  logic [CODE_W-1:0] prev_code, prev_code_next;

  logic [23:0]       buf_s, buf_cat, buf_shift;
  logic [4:0]        held_s, held_cat, held_left;
  logic [3:0]        width_s;
  logic [FREE_W-1:0] free_s, free_inc, grow_at;
  prev_mode_t        mode_s;
  logic [CODE_W-1:0] prev_s, code, code_mask;
  logic              have;
  logic              accept;

  assign code_stream.ready = cmd_ready;
  assign cmd_valid         = code_stream.valid;
  assign accept            = code_stream.valid && cmd_ready;

  always_comb begin
    buf_s   = code_stream.new_strip ? '0 : bitbuf;
    held_s  = code_stream.new_strip ? '0 : held;
    width_s = code_stream.new_strip ? CW_MIN : width;
    free_s  = code_stream.new_strip ? FIRST_FREE : free_idx;
    mode_s  = code_stream.new_strip ? PV_NONE : mode;
    prev_s  = code_stream.new_strip ? '0 : prev_code;

    // codes are packed msb first
    buf_cat   = {buf_s[15:0], code_stream.in_byte};
    held_cat  = held_s + 5'd8;
    have      = held_cat >= {1'b0, width_s};
    held_left = held_cat - {1'b0, width_s};
    buf_shift = buf_cat >> held_left;
    code_mask = 12'((13'd1 << width_s) - 13'd1);
    code      = buf_shift[CODE_W-1:0] & code_mask;
    free_inc  = free_s + 13'd1;
    grow_at   = (13'd1 << width_s) - 13'd1;

    bitbuf_next    = buf_cat;
    held_next      = held_cat;
    width_next     = width_s;
    free_idx_next  = free_s;
    mode_next      = mode_s;
    prev_code_next = prev_s;

    cmd.new_strip = code_stream.new_strip;
    cmd.kind      = K_NONE;
    cmd.code      = code;
    cmd.prev      = prev_s;
    cmd.slot      = free_s[CODE_W-1:0];

    if (have) begin
      bitbuf_next = buf_cat & ((24'd1 << held_left) - 24'd1);
      held_next   = held_left;
      priority if (code == CLR_CODE) begin
        cmd.kind      = K_CLEAR;
        free_idx_next = FIRST_FREE;
        width_next    = CW_MIN;
        mode_next     = PV_CLEARED;
      end else if (code == END_CODE) begin
        cmd.kind = K_EOI;
      end else if (mode_s == PV_CLEARED) begin
        if (code >= LIT_LIMIT) begin
          cmd.kind = K_INVALID;
        end else begin
          cmd.kind       = K_LITERAL;
          mode_next      = PV_CODE;
          prev_code_next = code;
        end
      end else if (mode_s == PV_NONE || free_s >= FREE_LIMIT || {1'b0, code} > free_s) begin
        cmd.kind = K_INVALID;
      end else begin
        cmd.kind       = K_STRING;
        free_idx_next  = free_inc;
        // early change: widen as the next slot reaches 2^width - 1
        if (width_s < CW_MAX && free_inc == grow_at) begin
          width_next = width_s + 4'd1;
        end
        mode_next      = PV_CODE;
        prev_code_next = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitbuf    <= '0;
      held      <= '0;
      width     <= CW_MIN;
      free_idx  <= FIRST_FREE;
      mode      <= PV_NONE;
      prev_code <= '0;
    end else if (accept) begin
      bitbuf    <= bitbuf_next;
      held      <= held_next;
      width     <= width_next;
      free_idx  <= free_idx_next;
      mode      <= mode_next;
      prev_code <= prev_code_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lzwvd_expand.sv
`default_nettype none
`include "lzw_variable_width_decoder_macros.svh"
module lzwvd_expand import lzwvd_pkg::*; #(
  parameter int unsigned BYTES_PER_CHUNK = CHUNK_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_ready,
  lzwvd_out_if.source       byte_stream,
  input  logic              cfg_wr_en,
  input  logic [OLEN_W-1:0] cfg_wr_data
);

  localparam int unsigned TAB_AW = $clog2(TABLE_ENTRIES);

  exp_state_t        state, state_next;
  logic [OLEN_W-1:0] olen;
  logic [OLEN_W-1:0] bw, bw_next;
  status_t           done, done_next;

  cmd_t              cmd_r;
  logic [CODE_W-1:0] cur;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  take;
  logic [LEN_W-1:0]  pos;
  logic              pend;
  logic [CNT_W-1:0]  cnt;
  logic [7:0]        chunk [CHUNK_MAX];
  logic [63:0]       words [8];

  tab_entry_t        tab [TABLE_ENTRIES];
  tab_entry_t        q_a, q_b, new_ent;
  logic [TAB_AW-1:0] addr_a, addr_b;
  logic              tab_we;

  logic [7:0]        stk [TABLE_ENTRIES];
  logic [7:0]        stack_q, stk_wdata;
  logic              stk_we;

  logic [OLEN_W-1:0] eff_bw, bw_base, remain, bw_emit;
  status_t           eff_done;
  logic [LEN_W-1:0]  len_code, len_sel, take_calc;
  logic [7:0]        first_p, first_c;
  logic              hit, issue, out_free, limit_met;

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !byte_stream.valid || byte_stream.ready;

  always_comb begin
    eff_bw    = cmd.new_strip ? '0 : bw;
    eff_done  = cmd.new_strip ? STAT_RUN : done;
    limit_met = eff_bw >= olen;

    first_p = (cmd_r.prev < LIT_LIMIT) ? cmd_r.prev[7:0] : q_a.first;
    first_c = (cmd_r.code < LIT_LIMIT) ? cmd_r.code[7:0] : q_b.first;
    new_ent.prefix = cmd_r.prev;
    new_ent.first  = first_p;
    new_ent.last   = (cmd_r.code < cmd_r.slot) ? first_c : first_p;
    new_ent.len    = ((cmd_r.prev < LIT_LIMIT) ? LEN_W'(1) : q_a.len) + LEN_W'(1);
    if (cmd_r.code < LIT_LIMIT) begin
      len_code = LEN_W'(1);
    end else if (cmd_r.code == cmd_r.slot) begin
      len_code = new_ent.len;
    end else begin
      len_code = q_b.len;
    end

    // output is cut at the strip length
    bw_base   = (state == S_IDLE) ? eff_bw : bw;
    len_sel   = (state == S_IDLE) ? LEN_W'(1) : len_code;
    remain    = olen - bw_base;
    take_calc = ((OLEN_W)'(len_sel) < remain) ? len_sel : remain[LEN_W-1:0];
    bw_emit   = bw_base + (OLEN_W)'(take_calc);
    hit       = bw_emit >= olen;

    issue = (pos < take) && ((cnt + CNT_W'(pend)) < CNT_W'(BYTES_PER_CHUNK));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && eff_done == STAT_RUN) begin
          if (limit_met) begin
            state_next = S_SEND;
          end else begin
            unique case (cmd.kind)
              K_EOI, K_INVALID: state_next = S_SEND;
              K_LITERAL:        state_next = S_WALK;
              K_STRING:         state_next = S_LOOKUP;
              default:          state_next = S_IDLE;
            endcase
          end
        end
      end
      S_LOOKUP: state_next = S_FETCH;
      S_FETCH:  state_next = S_WALK;
      S_WALK: begin
        if (cur < LIT_LIMIT || idx == '0) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!issue) begin
          state_next = S_SEND;
        end
      end
      S_SEND: begin
        if (out_free) begin
          state_next = (pos == take) ? S_IDLE : S_DRAIN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    addr_a    = cmd.prev;
    addr_b    = cmd.code;
    tab_we    = 1'b0;
    stk_we    = 1'b0;
    stk_wdata = q_a.last;
    bw_next   = bw;
    done_next = done;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          bw_next   = eff_bw;
          done_next = eff_done;
          if (eff_done == STAT_RUN) begin
            if (limit_met) begin
              done_next = STAT_COMPLETE;
            end else begin
              unique case (cmd.kind)
                K_EOI:     done_next = STAT_SHORT;
                K_INVALID: done_next = STAT_INVALID;
                K_LITERAL: begin
                  bw_next = bw_emit;
                  if (hit) begin
                    done_next = STAT_COMPLETE;
                  end
                end
                default: done_next = eff_done;
              endcase
            end
          end
        end
      end
      S_LOOKUP: begin
        tab_we  = 1'b1;
        bw_next = bw_emit;
        if (hit) begin
          done_next = STAT_COMPLETE;
        end
      end
      S_FETCH: addr_a = cur;
      S_WALK: begin
        // chain walk from the last byte back to the first
        stk_we = 1'b1;
        addr_a = q_a.prefix;
        if (cur < LIT_LIMIT) begin
          stk_wdata = cur[7:0];
        end
      end
      default: addr_a = cmd.prev;
    endcase
  end

  always_comb begin
    for (int w = 0; w < 8; w++) begin
      for (int b = 0; b < 8; b++) begin
        words[w][8*b +: 8] = chunk[8*w + b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      olen              <= OLEN_RESET;
      bw                <= '0;
      done              <= STAT_RUN;
      byte_stream.valid <= 1'b0;
    end else begin
      state <= state_next;
      bw    <= bw_next;
      done  <= done_next;
      if (cfg_wr_en) begin
        olen <= cfg_wr_data;
      end
      if (state == S_SEND && out_free) begin
        byte_stream.valid <= 1'b1;
      end else if (byte_stream.ready) begin
        byte_stream.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd_r <= cmd;
        cur   <= cmd.code;
        idx   <= '0;
        take  <= take_calc;
        pos   <= '0;
        pend  <= 1'b0;
        cnt   <= '0;
        for (int i = 0; i < CHUNK_MAX; i++) begin
          chunk[i] <= '0;
        end
        if (!(cmd.kind == K_LITERAL) || limit_met) begin
          take <= '0;
        end
      end
      S_LOOKUP: begin
        idx  <= len_code - LEN_W'(1);
        take <= take_calc;
      end
      S_WALK: begin
        cur  <= q_a.prefix;
        idx  <= idx - LEN_W'(1);
        pos  <= '0;
        pend <= 1'b0;
        cnt  <= '0;
      end
      S_DRAIN: begin
        if (pend) begin
          chunk[cnt[5:0]] <= stack_q;
          cnt             <= cnt + CNT_W'(1);
        end
        pend <= issue;
        if (issue) begin
          pos <= pos + LEN_W'(1);
        end
      end
      S_SEND: begin
        if (out_free) begin
          byte_stream.data_word0 <= words[0];
          byte_stream.data_word1 <= words[1];
          byte_stream.data_word2 <= words[2];
          byte_stream.data_word3 <= words[3];
          byte_stream.data_word4 <= words[4];
          byte_stream.data_word5 <= words[5];
          byte_stream.data_word6 <= words[6];
          byte_stream.data_word7 <= words[7];
          byte_stream.byte_count <= cnt;
          byte_stream.last_chunk <= (pos == take);
          byte_stream.status     <= (pos == take) ? done : STAT_RUN;
          cnt  <= '0;
          pend <= 1'b0;
          for (int i = 0; i < CHUNK_MAX; i++) begin
            chunk[i] <= '0;
          end
        end
      end
      default: pend <= 1'b0;
    endcase
  end

  // string table, two registered read ports
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab[cmd_r.slot] <= new_ent;
    end
    q_a <= tab[addr_a];
    q_b <= tab[addr_b];
  end

  // string stack, filled back to front then read in order
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[idx] <= stk_wdata;
    end
    stack_q <= stk[pos];
  end

  `LZWVD_ASSERT_IMPL(a_pos_bound, state == S_DRAIN, pos <= take, "drain ran past the string")
  `LZWVD_ASSERT_IMPL(a_cnt_bound, state == S_SEND, cnt <= CNT_W'(BYTES_PER_CHUNK), "chunk overfilled")
  `LZWVD_ASSERT_NEXT(a_done_sticky, done != STAT_RUN && !(state == S_IDLE && cmd_valid && cmd.new_strip), done != STAT_RUN, "status cleared without a new strip")

endmodule
`default_nettype wire

>>> sim/lzwvd_tb_if.sv
`timescale 1ns / 100ps
// the channels use the block's own interfaces; this file holds the word type the
// checker keeps for each expected output chunk
package lzwvd_tb_pkg;
  typedef struct {
    logic [63:0] word [8];
    logic [6:0]  byte_count;
    logic        last_chunk;
    logic [1:0]  status;
  } chunk_t;
endpackage

>>> sim/lzwvd_checker.sv
`timescale 1ns / 100ps
module lzwvd_checker import lzwvd_pkg::*; import lzwvd_tb_pkg::*; (
  input logic              clk,
  input logic              rst,
  lzwvd_in_if              code_stream,
  lzwvd_out_if             byte_stream,
  input logic              cfg_wr_en,
  input logic [OLEN_W-1:0] cfg_wr_data,
  output int               errors,
  output int               pending
);
  // decoder copy
  logic [CODE_W-1:0] tab_prefix [TABLE_ENTRIES];
  logic [7:0]        tab_first [TABLE_ENTRIES];
  logic [7:0]        tab_last [TABLE_ENTRIES];
  logic [12:0]       tab_len [TABLE_ENTRIES];
  logic [7:0]        step_bytes [TABLE_ENTRIES];
  logic [7:0]        str_buf [TABLE_ENTRIES];
  logic [OLEN_W-1:0] strip_len;
  logic [23:0]       bitbuf;
  int unsigned       held, width, free_idx, prev_code, written;
  status_t           strip_status;
  chunk_t            chunk_q [$];

  localparam int unsigned PREV_NONE = 4096, PREV_CLEARED = 4097;

  assign pending = chunk_q.size();

  task automatic strip_init();
    bitbuf = 0; held = 0; width = CW_MIN; free_idx = FIRST_FREE;
    prev_code = PREV_NONE; written = 0; strip_status = STAT_RUN;
  endtask

  function automatic int unsigned first_byte(int unsigned c);
    return c < 256 ? c : tab_first[c];
  endfunction

  function automatic int unsigned str_len(int unsigned c);
    return c < 256 ? 1 : tab_len[c];
  endfunction

  function automatic int unsigned append_string(int unsigned c);
    int unsigned len, remain, take;
    len = str_len(c);
    remain = strip_len - written;
    if (len > TABLE_ENTRIES) len = TABLE_ENTRIES;
    if (len == 0) len = 1;
    for (int i = len; i > 0; i--) begin
      if (c < 256) str_buf[i-1] = c[7:0];
      else begin
        str_buf[i-1] = tab_last[c];
        c = tab_prefix[c];
      end
    end
    take = len < remain ? len : remain;
    for (int i = 0; i < take; i++) step_bytes[i] = str_buf[i];
    written += take;
    if (written >= strip_len) strip_status = STAT_COMPLETE;
    return take;
  endfunction

  function automatic int unsigned decode_code(int unsigned code);
    int unsigned f;
    if (code == END_CODE) begin
      strip_status = STAT_SHORT;
      return 0;
    end
    if (code == CLR_CODE) begin
      free_idx = FIRST_FREE; width = CW_MIN; prev_code = PREV_CLEARED;
      return 0;
    end
    if (prev_code == PREV_CLEARED) begin
      if (code > 255) begin
        strip_status = STAT_INVALID;
        return 0;
      end
      prev_code = code;
      return append_string(code);
    end
    if (prev_code == PREV_NONE || free_idx >= TABLE_ENTRIES || code > free_idx) begin
      strip_status = STAT_INVALID;
      return 0;
    end
    f = free_idx;
    tab_prefix[f] = prev_code;
    tab_first[f] = first_byte(prev_code);
    tab_last[f] = code < free_idx ? first_byte(code) : first_byte(prev_code);
    tab_len[f] = str_len(prev_code) + 1;
    free_idx++;
    if (width < CW_MAX && free_idx == (1 << width) - 1) width++;
    prev_code = code;
    return append_string(code);
  endfunction

  task automatic predict_byte(logic [7:0] b, logic ns);
    status_t was;
    int unsigned nout, chunks, cnt, code;
    chunk_t ch;
    nout = 0;
    if (ns) strip_init();
    was = strip_status;
    if (strip_status == STAT_RUN && written >= strip_len) strip_status = STAT_COMPLETE;
    else if (strip_status == STAT_RUN) begin
      bitbuf = {bitbuf[15:0], b};
      held += 8;
      if (held >= width) begin
        code = (bitbuf >> (held - width)) & ((1 << width) - 1);
        held -= width;
        bitbuf &= (24'd1 << held) - 1;
        nout = decode_code(code);
      end
    end
    if (nout == 0 && strip_status == was) return;
    chunks = nout ? (nout + 63) / 64 : 1;
    for (int k = 0; k < chunks; k++) begin
      cnt = nout - k * 64 < 64 ? nout - k * 64 : 64;
      for (int j = 0; j < 8; j++) ch.word[j] = '0;
      for (int j = 0; j < cnt; j++) ch.word[j/8][(j%8)*8 +: 8] = step_bytes[k*64 + j];
      ch.byte_count = 7'(cnt);
      ch.last_chunk = k + 1 == chunks;
      ch.status = k + 1 == chunks ? strip_status : STAT_RUN;
      chunk_q.push_back(ch);
    end
  endtask

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %h got %h", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    chunk_t e;
    logic [63:0] got [8];
    if (rst) begin
      errors = 0;
      strip_len = OLEN_RESET;
      strip_init();
      chunk_q.delete();
    end else begin
      if (cfg_wr_en) strip_len = cfg_wr_data;
      if (byte_stream.valid && byte_stream.ready) begin
        got = '{byte_stream.data_word0, byte_stream.data_word1, byte_stream.data_word2,
                byte_stream.data_word3, byte_stream.data_word4, byte_stream.data_word5,
                byte_stream.data_word6, byte_stream.data_word7};
        if (chunk_q.size() == 0) report("unexpected word", 0, byte_stream.byte_count);
        else begin
          e = chunk_q.pop_front();
          for (int j = 0; j < 8; j++)
            if (got[j] !== e.word[j]) report($sformatf("data_word%0d", j), e.word[j], got[j]);
          if (byte_stream.byte_count !== e.byte_count)
            report("byte_count", e.byte_count, byte_stream.byte_count);
          if (byte_stream.last_chunk !== e.last_chunk)
            report("last_chunk", e.last_chunk, byte_stream.last_chunk);
          if (byte_stream.status !== e.status) report("status", e.status, byte_stream.status);
        end
      end
      if (code_stream.valid && code_stream.ready)
        predict_byte(code_stream.in_byte, code_stream.new_strip);
    end
  end
endmodule

>>> sim/lzw_variable_width_decoder_test.sv
`timescale 1ns / 100ps
module lzw_variable_width_decoder_test;
  import lzwvd_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [OLEN_W-1:0] cfg_wr_data = '0;
  int errors, pending;
  bit calm = 0, hold_off = 0;
  int unsigned sent = 0;

  lzwvd_in_if  code_stream ();
  lzwvd_out_if byte_stream ();

  lzw_variable_width_decoder uut (
    .clk(clk), .rst(rst), .code_stream(code_stream), .byte_stream(byte_stream),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data));

  lzwvd_checker chk (
    .clk(clk), .rst(rst), .code_stream(code_stream), .byte_stream(byte_stream),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .errors(errors), .pending(pending));

  always #5 clk = ~clk;

  initial begin
    code_stream.valid = 0;
    code_stream.in_byte = 0;
    code_stream.new_strip = 0;
    byte_stream.ready = 0;
  end

  // receiver stalls
  always @(negedge clk)
    byte_stream.ready <= !rst && !hold_off && (calm || $urandom_range(99) >= 9);

  // code packer: bits accumulate MSB first and leave as bytes
  logic [31:0] pack_bits;
  int unsigned pack_n, cw, nfree;
  bit first_of_strip;

  // valid stays up between bytes sent back to back
  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(99) < 9) begin
      code_stream.valid <= 0;
      @(negedge clk);
    end
    code_stream.valid <= 1;
    code_stream.in_byte <= b;
    code_stream.new_strip <= first_of_strip;
    first_of_strip = 0;
    @(posedge clk);
    while (!code_stream.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic put_code(int unsigned code);
    pack_bits = (pack_bits << cw) | code;
    pack_n += cw;
    while (pack_n >= 8) begin
      pack_n -= 8;
      send_byte(8'(pack_bits >> pack_n));
    end
  endtask

  // track the table growth the way the decoder does, so widths line up
  task automatic put_clear();
    put_code(CLR_CODE);
    cw = 9; nfree = 258;
  endtask

  task automatic code_next(int unsigned code, bit after_clear);
    put_code(code);
    if (!after_clear && nfree < 4096) begin
      nfree++;
      if (cw < 12 && nfree == (1 << cw) - 1) cw++;
    end
  endtask

  task automatic flush_bits();
    if (pack_n > 0) put_code(0);
  endtask

  task automatic begin_strip();
    first_of_strip = 1; pack_bits = 0; pack_n = 0; cw = 9; nfree = 258;
  endtask

  task automatic settle();
    code_stream.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_length(logic [OLEN_W-1:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  // well-formed strip with random content; noise codes now and then when noisy is set
  task automatic random_strip(int unsigned codes, bit noisy);
    int unsigned c;
    begin_strip();
    put_clear();
    code_next($urandom_range(255), 1);
    for (int i = 0; i < codes; i++) begin
      if (noisy && $urandom_range(19) == 0) c = $urandom_range((1 << cw) - 1);
      else if ($urandom_range(3) == 0) c = $urandom_range(255);
      else c = $urandom_range(nfree, 258 < nfree ? 258 : nfree);
      if (c == CLR_CODE) begin
        put_clear();
        code_next($urandom_range(255), 1);
      end else code_next(c, 0);
    end
    if ($urandom_range(1)) put_code(END_CODE);
    flush_bits();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 0;
    calm = 1;

    // directed: literals 0/255, repeated clear, string, code equal to free index, eoi
    begin_strip();
    put_clear(); put_clear();
    code_next(8'hff, 1); code_next(0, 0); code_next(258, 0); code_next(260, 0);
    code_next(8'haa, 0); code_next(8'h55, 0);
    put_code(END_CODE); flush_bits();
    send_byte(8'hff); // ignored after end
    // not opened by clear
    begin_strip(); put_code(65); flush_bits();
    // non-literal after clear
    begin_strip(); put_clear(); put_code(300); flush_bits();
    // code beyond table
    begin_strip(); put_clear(); code_next(1, 1); put_code(400); flush_bits();
    settle();

    // length cut
    set_length(1);
    begin_strip(); put_clear(); code_next(7, 1); code_next(258, 0); flush_bits();
    settle();
    set_length(5);
    begin_strip(); put_clear(); code_next(3, 1); code_next(258, 0); code_next(259, 0);
    flush_bits();
    settle();
    // limit already met after the length is lowered mid strip
    set_length(100);
    begin_strip(); put_clear(); code_next(3, 1); code_next(4, 0);
    settle();
    set_length(1);
    send_byte(8'h12);
    settle();

    calm = 0;
    set_length(27'h7ffffff);
    // long strip crossing the first width change
    begin_strip();
    put_clear(); code_next(9, 1);
    for (int i = 0; i < 254; i++) code_next(i % 3 ? 258 : $urandom_range(255), 0);
    code_next(258, 0);
    flush_bits();
    settle();

    // receiver held off while input keeps coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      begin
        random_strip(15, 0);
        code_stream.valid <= 0;
      end
    join
    settle();

    set_length(OLEN_RESET);
    while (sent < 350) begin
      random_strip($urandom_range(4, 12), $urandom_range(3) == 0);
      if ($urandom_range(3) == 0) settle();
      if ($urandom_range(5) == 0) begin
        settle();
        set_length(27'($urandom_range(1, 300)));
      end
    end
    settle();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/lzwvd_pkg.sv
rtl/lzwvd_if.sv
rtl/lzwvd_cmd_fifo.sv
rtl/lzwvd_unpack.sv
rtl/lzwvd_expand.sv
rtl/lzw_variable_width_decoder.sv
sim/lzwvd_tb_if.sv
sim/lzwvd_checker.sv
sim/lzw_variable_width_decoder_test.sv
